@@ hdl/obb_pkg.sv @@
// ----------------------------------------------------------------------------
// obb_pkg
// Shared widths and constants for the 2D oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;
    localparam int CW      = 32;  // centre, Q16.16 signed
    localparam int AW      = 16;  // axis component, Q2.14 signed
    localparam int EW      = 31;  // half extent, Q15.16 unsigned
    localparam int NUM_AX  = 4;   // candidate separating axes
    localparam int NUM_BOX = 2;
    localparam int DW      = CW + 1;        // centre difference
    localparam int UW      = AW + 1;        // axis component after negation
    localparam int PW      = DW + UW;       // centre difference times axis
    localparam int QW      = AW + UW;       // axis dot product term
    localparam int RW      = 64;            // one radius, Q.44
    localparam int FRAC_SH = 14;            // Q.30 to Q.44
endpackage

@@ hdl/obb_overlap_test_2d_top.sv @@
// ----------------------------------------------------------------------------
// obb_overlap_test_2d_top
// Separating axis overlap test for a pair of 2D oriented boxes.
// ----------------------------------------------------------------------------
// Usage: drive a pair of boxes on the i_ ports and raise start; the item is
// taken at the clock edge where start is high and busy is low. busy is tied
// low, so a new item can be taken every cycle.
// The result appears on o_overlap together with a one-cycle o_done strobe
// once the item has passed all pipeline stages; results leave in the order
// items came in. Throughput is one item per cycle: a six-stage pipeline
// (input register, products, dot sums and magnitudes, radius products,
// radius sums, compare) with valid bits riding along with the data.
// The receiver has no way to stall, so nothing is ever held back.
// Reset clears the valid bits only; items in flight are dropped and no
// strobe is raised until new items arrive.
// o_overlap is 1 when the projections of both boxes meet on all four box
// axes, touching included.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [obb_pkg::CW-1:0]   i_a_center_x,
    input  logic signed [obb_pkg::CW-1:0]   i_a_center_y,
    input  logic signed [obb_pkg::AW-1:0]   i_a_axis_x,
    input  logic signed [obb_pkg::AW-1:0]   i_a_axis_y,
    input  logic        [obb_pkg::EW-1:0]   i_a_half_width,
    input  logic        [obb_pkg::EW-1:0]   i_a_half_height,
    input  logic signed [obb_pkg::CW-1:0]   i_b_center_x,
    input  logic signed [obb_pkg::CW-1:0]   i_b_center_y,
    input  logic signed [obb_pkg::AW-1:0]   i_b_axis_x,
    input  logic signed [obb_pkg::AW-1:0]   i_b_axis_y,
    input  logic        [obb_pkg::EW-1:0]   i_b_half_width,
    input  logic        [obb_pkg::EW-1:0]   i_b_half_height,
    output logic                            o_done,
    output logic                            o_overlap
);
    localparam int NA = obb_pkg::NUM_AX;
    localparam int NB = obb_pkg::NUM_BOX;
    localparam int DW = obb_pkg::DW;
    localparam int UW = obb_pkg::UW;
    localparam int PW = obb_pkg::PW;
    localparam int QW = obb_pkg::QW;
    localparam int AW = obb_pkg::AW;
    localparam int EW = obb_pkg::EW;
    localparam int RW = obb_pkg::RW;
    localparam int SW = PW + 1;              // centre projection sum
    localparam int MW = PW;                  // its magnitude
    localparam int XW = QW + 1;              // axis dot sum
    localparam int GW = AW + AW;             // its magnitude
    localparam int TW = RW + 1;              // sum of both radii
    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;

    // stage 1: input register
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [UW-1:0] r_ux [NA];
    logic signed [UW-1:0] r_uy [NA];
    logic signed [AW-1:0] r_px [NB];
    logic signed [AW-1:0] r_py [NB];
    logic [EW-1:0] r_hw1 [NB];
    logic [EW-1:0] r_hh1 [NB];

    // stage 2: products
    logic signed [PW-1:0] r_pdx [NA];
    logic signed [PW-1:0] r_pdy [NA];
    logic signed [QW-1:0] r_pxux [NA][NB];
    logic signed [QW-1:0] r_pyuy [NA][NB];
    logic signed [QW-1:0] r_pyux [NA][NB];
    logic signed [QW-1:0] r_pxuy [NA][NB];
    logic [EW-1:0] r_hw2 [NB];
    logic [EW-1:0] r_hh2 [NB];

    // stage 3: sums and magnitudes
    logic [MW-1:0] r_dm3 [NA];
    logic [GW-1:0] r_mex [NA][NB];
    logic [GW-1:0] r_mey [NA][NB];
    logic [EW-1:0] r_hw3 [NB];
    logic [EW-1:0] r_hh3 [NB];

    // stage 4: radius products
    logic [MW-1:0] r_dm4 [NA];
    logic [RW-2:0] r_rw [NA][NB];
    logic [RW-2:0] r_rh [NA][NB];

    // stage 5: radii
    logic [MW-1:0] r_dm5 [NA];
    logic [RW-1:0] r_rad [NA][NB];

    // stage 6: result
    logic r_ovl;

    logic signed [SW-1:0] n_ds [NA];
    logic signed [XW-1:0] n_ex [NA][NB];
    logic signed [XW-1:0] n_ey [NA][NB];
    logic [NA-1:0]        n_hit;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= DW'(i_b_center_x) - DW'(i_a_center_x);
        r_dy <= DW'(i_b_center_y) - DW'(i_a_center_y);
        r_ux[0] <= UW'(i_a_axis_x);
        r_uy[0] <= UW'(i_a_axis_y);
        r_ux[1] <= UW'(i_b_axis_x);
        r_uy[1] <= UW'(i_b_axis_y);
        // y axes: x axis turned a quarter turn anticlockwise
        r_ux[2] <= -UW'(i_a_axis_y);
        r_uy[2] <= UW'(i_a_axis_x);
        r_ux[3] <= -UW'(i_b_axis_y);
        r_uy[3] <= UW'(i_b_axis_x);
        r_px[0] <= i_a_axis_x;
        r_py[0] <= i_a_axis_y;
        r_px[1] <= i_b_axis_x;
        r_py[1] <= i_b_axis_y;
        r_hw1[0] <= i_a_half_width;
        r_hh1[0] <= i_a_half_height;
        r_hw1[1] <= i_b_half_width;
        r_hh1[1] <= i_b_half_height;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NA; k++) begin
            r_pdx[k] <= PW'(r_dx) * PW'(r_ux[k]);
            r_pdy[k] <= PW'(r_dy) * PW'(r_uy[k]);
            for (int j = 0; j < NB; j++) begin
                r_pxux[k][j] <= QW'(r_px[j]) * QW'(r_ux[k]);
                r_pyuy[k][j] <= QW'(r_py[j]) * QW'(r_uy[k]);
                r_pyux[k][j] <= QW'(r_py[j]) * QW'(r_ux[k]);
                r_pxuy[k][j] <= QW'(r_px[j]) * QW'(r_uy[k]);
            end
        end
        r_hw2 <= r_hw1;
        r_hh2 <= r_hh1;
    end

    always_comb begin
        for (int k = 0; k < NA; k++) begin
            n_ds[k] = SW'(r_pdx[k]) + SW'(r_pdy[k]);
            for (int j = 0; j < NB; j++) begin
                n_ex[k][j] = XW'(r_pxux[k][j]) + XW'(r_pyuy[k][j]);
                n_ey[k][j] = XW'(r_pxuy[k][j]) - XW'(r_pyux[k][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NA; k++) begin
            r_dm3[k] <= MW'(n_ds[k][SW-1] ? -n_ds[k] : n_ds[k]);
            for (int j = 0; j < NB; j++) begin
                r_mex[k][j] <= GW'(n_ex[k][j][XW-1] ? -n_ex[k][j] : n_ex[k][j]);
                r_mey[k][j] <= GW'(n_ey[k][j][XW-1] ? -n_ey[k][j] : n_ey[k][j]);
            end
        end
        r_hw3 <= r_hw2;
        r_hh3 <= r_hh2;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NA; k++) begin
            r_dm4[k] <= r_dm3[k];
            for (int j = 0; j < NB; j++) begin
                r_rw[k][j] <= (RW-1)'(r_hw3[j]) * (RW-1)'(r_mex[k][j]);
                r_rh[k][j] <= (RW-1)'(r_hh3[j]) * (RW-1)'(r_mey[k][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NA; k++) begin
            r_dm5[k] <= r_dm4[k];
            for (int j = 0; j < NB; j++) begin
                r_rad[k][j] <= RW'(r_rw[k][j]) + RW'(r_rh[k][j]);
            end
        end
    end

    // separated on an axis when the scaled centre distance exceeds the sum of both radii
    always_comb begin
        for (int k = 0; k < NA; k++) begin
            n_hit[k] = ({TW'(r_dm5[k]), {obb_pkg::FRAC_SH{1'b0}}} <=
                        (TW + obb_pkg::FRAC_SH)'(TW'(r_rad[k][0]) + TW'(r_rad[k][1])));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovl <= &n_hit;
    end

    assign o_done    = r_vld[NSTG-1];
    assign o_overlap = r_ovl;

endmodule
